// ===== src/kah_pkg.sv =====
package kah_pkg;

  localparam int TABLE_ENTRIES_DEF = 256;
  localparam int KEY_W             = 32;
  localparam int AMOUNT_W          = 32;
  localparam int TOTAL_W           = 48;
  localparam int SLOT_W            = 8;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_FULL      = 3'd2,
    ST_KEPT      = 3'd3,
    ST_RELEASED  = 3'd4,
    ST_NOT_FOUND = 3'd5,
    ST_UNDERFLOW = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_SETUP,
    S_SCAN,
    S_DRAIN,
    S_TOT_RD,
    S_EXEC
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clr_en;
    logic load;
    logic mod_step;
    logic scan_start;
    logic scan_step;
    logic tot_rd;
    logic exec;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic mod_last;
    logic scan_last;
    logic out_busy;
  } dp_stat_t;

endpackage

// ===== src/keyed_accumulator_hash_table_top.sv =====
// result path: after a request is accepted, a reciprocal key-modulo step, the key table scan
//   (one read per slot), a drain state and the total read precede the update, which sets out_tvalid;
//   one request at a time, accepted only in idle; a result held by out_tready stalls the next
// reset: synchronous active-low; afterwards a clearing pass, one write per slot, empties the key
//   table, and in_tready stays low until it ends
module keyed_accumulator_hash_table_top #(
  parameter int TABLE_ENTRIES = kah_pkg::TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // key [31:0], amount [63:32]
  input  logic [0:0]  in_tuser,   // opcode [0] (0 add, 1 subtract)
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // slot [7:0], total_after [55:8]
  output logic [2:0]  out_tuser   // status [2:0]
);
  import kah_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  status_t  out_status;
  logic [SLOT_W-1:0]  out_slot;
  logic [TOTAL_W-1:0] out_total;

  // sequencer: clear pass, modulo, probe scan, total read, update
  kah_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // tables, remainder unit, compare pipeline and result register
  kah_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_opcode  (in_tuser[0]),
    .in_key     (in_tdata[31:0]),
    .in_amount  (in_tdata[63:32]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_status (out_status),
    .out_slot   (out_slot),
    .out_total  (out_total)
  );

  // the result register lets a new request start while a result waits
  assign out_tdata = {out_total, out_slot};
  assign out_tuser = out_status;

endmodule

// ===== src/kah_ctrl.sv =====
module kah_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  kah_pkg::dp_stat_t stat,
  output kah_pkg::dp_cmd_t  cmd
);
  import kah_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:  if (stat.clr_last) state_nxt = S_IDLE;
      S_IDLE:   if (in_tvalid) state_nxt = S_MOD;
      S_MOD:    if (stat.mod_last) state_nxt = S_SETUP;
      S_SETUP:  state_nxt = S_SCAN;
      S_SCAN:   if (stat.scan_last) state_nxt = S_DRAIN;
      S_DRAIN:  state_nxt = S_TOT_RD;
      S_TOT_RD: state_nxt = S_EXEC;
      S_EXEC:   if (!stat.out_busy) state_nxt = S_IDLE;
      default:  state_nxt = S_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_CLEAR:  cmd.clr_en = 1'b1;
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      S_MOD:    cmd.mod_step   = 1'b1;
      S_SETUP:  cmd.scan_start = 1'b1;
      S_SCAN:   cmd.scan_step  = 1'b1;
      S_DRAIN:  ;
      S_TOT_RD: cmd.tot_rd     = 1'b1;
      S_EXEC:   cmd.exec       = !stat.out_busy;
      default:  ;
    endcase
  end

endmodule

// ===== src/kah_dp.sv =====
module kah_dp #(
  parameter int TABLE_ENTRIES = kah_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  kah_pkg::dp_cmd_t                 cmd,
  output kah_pkg::dp_stat_t                stat,
  input  logic                             in_opcode,
  input  logic [kah_pkg::KEY_W-1:0]        in_key,
  input  logic [kah_pkg::AMOUNT_W-1:0]     in_amount,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output kah_pkg::status_t                 out_status,
  output logic [kah_pkg::SLOT_W-1:0]       out_slot,
  output logic [kah_pkg::TOTAL_W-1:0]      out_total
);
  import kah_pkg::*;

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam logic [AW:0]   N_W    = (AW+1)'(TABLE_ENTRIES);
  localparam logic [AW-1:0] LAST_W = AW'(TABLE_ENTRIES - 1);
  // floor(2^32 / N): the quotient estimate is low by at most one
  localparam logic [KEY_W-1:0] RECIP = KEY_W'((64'd1 << KEY_W) / TABLE_ENTRIES);
  localparam logic [1:0]    MOD_LAST = 2'd2;

  // tables
  logic [KEY_W-1:0]   keys_mem   [TABLE_ENTRIES];
  logic [TOTAL_W-1:0] totals_mem [TABLE_ENTRIES];

  // request registers
  logic                op_r;
  logic [KEY_W-1:0]    key_r;
  logic [AMOUNT_W-1:0] amt_r;

  // remainder unit: reciprocal multiply, partial remainder, one correction
  logic [AW-1:0]        rem_r, rem_nxt;
  logic [1:0]           mod_cnt_r;
  logic [2*KEY_W-1:0]   prod_r;
  logic [AW:0]          qn_lo;
  logic [AW:0]          part_r, part_nxt;

  // scan
  logic [AW-1:0]      clr_ptr_r;
  logic [AW-1:0]      ptr_r;
  logic [AW-1:0]      step_r;
  logic               cmp_v_r;
  logic [AW-1:0]      cmp_addr_r;
  logic [KEY_W-1:0]   rd_key_r;
  logic               found_r;
  logic [AW-1:0]      found_slot_r;
  logic               empty_r;
  logic [AW-1:0]      empty_slot_r;
  logic [TOTAL_W-1:0] tot_r;

  // result
  logic               out_valid_r;
  status_t            status_r, res_status;
  logic [AW-1:0]      res_idx;
  logic [TOTAL_W-1:0] res_total, total_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [AW+SLOT_W-1:0] slot_ext;

  // table writes
  logic               ex_kwe, ex_twe;
  logic [KEY_W-1:0]   ex_kdata;
  logic [TOTAL_W-1:0] ex_tdata;
  logic               kwe;
  logic [AW-1:0]      kaddr;
  logic [KEY_W-1:0]   kdata;

  // arithmetic
  logic [TOTAL_W:0]   sum_w;
  logic [TOTAL_W-1:0] sat_sum, amt_w, diff;
  logic               under;

  // key - q*N lies in [0, 2N), so the low AW+1 bits are exact
  assign qn_lo    = prod_r[KEY_W +: AW+1] * N_W;
  assign part_nxt = key_r[AW:0] - qn_lo;
  assign rem_nxt  = (part_r >= N_W) ? AW'(part_r - N_W) : part_r[AW-1:0];

  assign stat.clr_last  = (clr_ptr_r == LAST_W);
  assign stat.mod_last  = (mod_cnt_r == MOD_LAST);
  assign stat.scan_last = (step_r == LAST_W);
  assign stat.out_busy  = out_valid_r && !out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_ptr_r   <= '0;
      cmp_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_en) clr_ptr_r <= clr_ptr_r + 1'b1;
      cmp_v_r <= cmd.scan_step;
      if (cmd.exec) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= in_opcode;
      key_r     <= in_key;
      amt_r     <= in_amount;
      mod_cnt_r <= '0;
    end
    if (cmd.mod_step) begin
      prod_r    <= {{KEY_W{1'b0}}, key_r} * {{KEY_W{1'b0}}, RECIP};
      part_r    <= part_nxt;
      rem_r     <= rem_nxt;
      mod_cnt_r <= mod_cnt_r + 1'b1;
    end
    if (cmd.scan_start) begin
      ptr_r   <= rem_r;
      step_r  <= '0;
      found_r <= 1'b0;
      empty_r <= 1'b0;
    end
    if (cmd.scan_step) begin
      ptr_r  <= (ptr_r == LAST_W) ? '0 : ptr_r + 1'b1;
      step_r <= step_r + 1'b1;
    end
    cmp_addr_r <= ptr_r;
    // first hit in probe order wins
    if (cmp_v_r) begin
      if (rd_key_r == key_r && !found_r) begin
        found_r      <= 1'b1;
        found_slot_r <= cmp_addr_r;
      end
      if (rd_key_r == '0 && !empty_r) begin
        empty_r      <= 1'b1;
        empty_slot_r <= cmp_addr_r;
      end
    end
    if (cmd.exec) begin
      status_r <= res_status;
      slot_r   <= slot_ext[SLOT_W-1:0];
      total_r  <= res_total;
    end
  end

  // key table: clearing pass or request update
  assign kwe   = cmd.clr_en || (cmd.exec && ex_kwe);
  assign kaddr = cmd.clr_en ? clr_ptr_r : res_idx;
  assign kdata = cmd.clr_en ? '0 : ex_kdata;

  always_ff @(posedge clk) begin
    if (kwe) keys_mem[kaddr] <= kdata;
    rd_key_r <= keys_mem[ptr_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && ex_twe) totals_mem[res_idx] <= ex_tdata;
    if (cmd.tot_rd) tot_r <= totals_mem[found_slot_r];
  end

  assign amt_w   = {{(TOTAL_W-AMOUNT_W){1'b0}}, amt_r};
  assign sum_w   = {1'b0, tot_r} + {1'b0, amt_w};
  assign sat_sum = sum_w[TOTAL_W] ? '1 : sum_w[TOTAL_W-1:0];
  assign under   = amt_w > tot_r;
  assign diff    = tot_r - amt_w;

  always_comb begin
    res_status = ST_NOT_FOUND;
    res_idx    = '0;
    res_total  = '0;
    ex_kwe     = 1'b0;
    ex_twe     = 1'b0;
    ex_kdata   = '0;
    ex_tdata   = '0;
    priority if (key_r == '0) begin
      res_status = ST_NOT_FOUND;
    end else if (!op_r) begin
      priority if (found_r) begin
        res_status = ST_ADDED;
        res_idx    = found_slot_r;
        res_total  = sat_sum;
        ex_twe     = 1'b1;
        ex_tdata   = sat_sum;
      end else if (empty_r) begin
        res_status = ST_INSERTED;
        res_idx    = empty_slot_r;
        res_total  = amt_w;
        ex_kwe     = 1'b1;
        ex_kdata   = key_r;
        ex_twe     = 1'b1;
        ex_tdata   = amt_w;
      end else begin
        res_status = ST_FULL;
      end
    end else if (found_r) begin
      res_idx = found_slot_r;
      priority if (under) begin
        res_status = ST_UNDERFLOW;
        ex_kwe     = 1'b1;
      end else if (diff == '0) begin
        res_status = ST_RELEASED;
        ex_kwe     = 1'b1;
      end else begin
        res_status = ST_KEPT;
        res_total  = diff;
        ex_twe     = 1'b1;
        ex_tdata   = diff;
      end
    end else begin
      res_status = ST_NOT_FOUND;
    end
  end

  assign slot_ext = {{SLOT_W{1'b0}}, res_idx};

  assign out_tvalid = out_valid_r;
  assign out_status = status_r;
  assign out_slot   = slot_r;
  assign out_total  = total_r;

endmodule
